>>> rtl/core/itoa_pkg.sv
// shared types, codes and constants of the integer to ascii formatter
package itoa_pkg;

  localparam int VALUE_W         = 64;
  localparam int CAP_W           = 16;
  localparam int FIELD_W         = 6;
  localparam int CNT_W           = 7;
  localparam int DIGIT_SLOTS_DEF = 32;
  localparam int MAX_WIDTH_DEF   = 63;

  // conversion types
  localparam logic [2:0] T_UDEC = 3'd0;
  localparam logic [2:0] T_SDEC = 3'd1;
  localparam logic [2:0] T_OCT  = 3'd2;
  localparam logic [2:0] T_LHEX = 3'd3;
  localparam logic [2:0] T_UHEX = 3'd4;

  // kinds of emitted word
  localparam logic [2:0] K_SIGN = 3'd0;
  localparam logic [2:0] K_LEAD = 3'd1;
  localparam logic [2:0] K_DIG  = 3'd2;
  localparam logic [2:0] K_TAIL = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // floor(x / 10) = (x * RECIP10) >> RECIP_SH for x below 655360
  localparam logic [19:0] RECIP10  = 20'd838861;
  localparam int          RECIP_SH = 23;

  localparam logic [15:0] CAP_RESET = 16'd255;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic       div_step;
    logic       store;
    logic       setup;
    logic       emit;
    logic [2:0] kind;
  } itoa_cmd_t;

  typedef struct packed {
    logic overflowed;
    logic is_dec;
    logic chunk_last;
    logic extract_done;
    logic total_zero;
    logic sign_first;
    logic neg;
    logic lead_zero;
    logic dig_zero;
    logic tail_zero;
    logic cap_hit;
    logic last_char;
    logic out_free;
  } itoa_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    if (upper && d >= 4'd10) begin
      c = c - 8'd32;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/itoa_req_if.sv
// input channel: one number with its conversion request
interface itoa_req_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [63:0] value;
  logic [2:0]         req_type;
  logic               pad_before;
  logic               zero_fill;
  logic [5:0]         field_width;
  logic [5:0]         digit_limit;

  modport source(output valid, restart, value, req_type, pad_before, zero_fill,
                 field_width, digit_limit, input ready);
  modport sink(input valid, restart, value, req_type, pad_before, zero_fill,
               field_width, digit_limit, output ready);
endinterface

>>> rtl/core/itoa_rsp_if.sv
// output channel: one character word per transfer
interface itoa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       overflow;

  modport source(output valid, out_char, last, overflow, input ready);
  modport sink(input valid, out_char, last, overflow, output ready);
endinterface

>>> rtl/core/itoa_cfg_if.sv
// configuration write channel for the buffer capacity
interface itoa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> rtl/core/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// req carries one 64-bit number with its conversion type, width, digit
// limit and padding flags; rsp returns the text one character word at a
// time, last set on the final word of the item. an item that yields no
// character returns no word. cfg writes the buffer capacity; a write is
// accepted every cycle and belongs between items.
// one item is worked at a time: req.ready is high only between items.
// decimal digits come from a divide by ten that handles 16 bits a cycle,
// so a digit takes 4 chunks and a store; octal and hex take one extract
// and one store a digit. then a setup step, then one character per free
// output slot: sign and padding in either order, digits, trailing spaces.
// when the count reaches the capacity an error word {0, last, overflow}
// ends the item and later items give only that word until a restart.
// reset clears the count, the overflow flag and the output valid flag and
// sets the capacity to 255. a stalled rsp holds its word; the sequencer
// simply waits for the output register to free up.
module integer_to_ascii_formatter
  import itoa_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input logic   clk,
  input logic   rst,
  itoa_req_if.sink   req,
  itoa_rsp_if.source rsp,
  itoa_cfg_if.sink   cfg
);

  itoa_cmd_t  cmd;
  itoa_stat_t st;

  // capacity register accepts a write every cycle
  assign cfg.ready = 1'b1;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .restart  (req.restart),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  itoa_dp #(
    .DIGIT_SLOTS (DIGIT_SLOTS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .value        (req.value),
    .req_type     (req.req_type),
    .pad_before   (req.pad_before),
    .zero_fill    (req.zero_fill),
    .field_width  (req.field_width),
    .digit_limit  (req.digit_limit),
    .cfg_valid    (cfg.valid),
    .cfg_data     (cfg.data),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_char     (rsp.out_char),
    .out_last     (rsp.last),
    .out_overflow (rsp.overflow)
  );

endmodule

>>> rtl/core/itoa_ctrl.sv
// sequencer of the formatter: extraction, setup and character emission
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       restart,
  output logic       in_ready,
  input  itoa_stat_t st,
  output itoa_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ERR   = 4'd2;
  localparam logic [3:0] S_EXTR  = 4'd3;
  localparam logic [3:0] S_STORE = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_SIGN1 = 4'd6;
  localparam logic [3:0] S_LEAD  = 4'd7;
  localparam logic [3:0] S_SIGN2 = 4'd8;
  localparam logic [3:0] S_DIG   = 4'd9;
  localparam logic [3:0] S_TAIL  = 4'd10;

  logic [3:0] state, state_next;
  logic       want;
  logic [2:0] want_kind;
  logic [3:0] want_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    want       = 1'b0;
    want_kind  = K_SIGN;
    want_after = S_IDLE;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.restart = restart;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: state_next = st.overflowed ? S_ERR : S_EXTR;
      S_ERR: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = K_ERR;
          state_next = S_IDLE;
        end
      end
      S_EXTR: begin
        if (st.is_dec) begin
          cmd.div_step = 1'b1;
          if (st.chunk_last) begin
            state_next = S_STORE;
          end
        end else begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = st.extract_done ? S_SETUP : S_EXTR;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_SIGN1;
      end
      S_SIGN1: begin
        if (st.total_zero) begin
          state_next = S_IDLE;
        end else if (st.sign_first && st.neg) begin
          want       = 1'b1;
          want_kind  = K_SIGN;
          want_after = S_LEAD;
        end else begin
          state_next = S_LEAD;
        end
      end
      S_LEAD: begin
        if (st.lead_zero) begin
          state_next = (!st.sign_first && st.neg) ? S_SIGN2 : S_DIG;
        end else begin
          want       = 1'b1;
          want_kind  = K_LEAD;
          want_after = S_LEAD;
        end
      end
      S_SIGN2: begin
        want       = 1'b1;
        want_kind  = K_SIGN;
        want_after = S_DIG;
      end
      S_DIG: begin
        if (st.dig_zero) begin
          state_next = S_TAIL;
        end else begin
          want       = 1'b1;
          want_kind  = K_DIG;
          want_after = S_DIG;
        end
      end
      S_TAIL: begin
        if (st.tail_zero) begin
          state_next = S_IDLE;
        end else begin
          want       = 1'b1;
          want_kind  = K_TAIL;
          want_after = S_TAIL;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // one character per free output slot, overflow ends the item
    if (want && st.out_free) begin
      cmd.emit = 1'b1;
      if (st.cap_hit) begin
        cmd.kind   = K_ERR;
        state_next = S_IDLE;
      end else begin
        cmd.kind   = want_kind;
        state_next = st.last_char ? S_IDLE : want_after;
      end
    end
  end

endmodule

>>> rtl/core/itoa_dp.sv
// datapath: digit extraction, digit store, counters and output register
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  itoa_cmd_t          cmd,
  output itoa_stat_t         st,
  input  logic signed [63:0] value,
  input  logic [2:0]         req_type,
  input  logic               pad_before,
  input  logic               zero_fill,
  input  logic [5:0]         field_width,
  input  logic [5:0]         digit_limit,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic               out_overflow
);

  localparam int PW = $clog2(DIGIT_SLOTS + 1);
  localparam int AW = $clog2(DIGIT_SLOTS);

  logic [CAP_W-1:0]   cap;
  logic [CAP_W-1:0]   count;
  logic               overflowed;
  logic [VALUE_W-1:0] work;
  logic [3:0]         rem;
  logic [1:0]         chunk;
  logic [PW-1:0]      place;
  logic               is_dec, is_hex, upper, neg, pb, zp;
  logic [5:0]         mw, lim;
  logic [CNT_W-1:0]   lead, tail, dig, remain;
  logic               sign_first;
  logic [7:0]         lead_ch;
  logic [AW-1:0]      dig_addr, dig_addr_next;
  logic [3:0]         rd_data;
  logic [3:0]         mem [DIGIT_SLOTS];

  logic [19:0]        dx;
  logic [42:0]        dprod;
  logic [15:0]        dq;
  logic [19:0]        dr;
  logic [VALUE_W-1:0] work_sh;
  logic [3:0]         digit;
  logic [5:0]         mw_sat;
  logic [CNT_W-1:0]   place_c, lim_c, mw_c, pad, nd;
  logic               zfill;
  logic               in_neg, in_hex, in_oct;
  logic [7:0]         ch;

  // one 16-bit chunk of the divide by ten per cycle
  assign dx    = {rem, work[63:48]};
  assign dprod = 43'(dx) * 43'(RECIP10);
  assign dq    = dprod[RECIP_SH+15:RECIP_SH];
  assign dr    = dx - 20'(dq) * 20'd10;

  assign work_sh = is_hex ? (work >> 4) : (work >> 3);
  assign digit   = is_dec ? rem : (is_hex ? work[3:0] : {1'b0, work[2:0]});

  assign in_oct = (req_type == T_OCT);
  assign in_hex = (req_type == T_LHEX) || (req_type == T_UHEX);
  assign in_neg = (req_type == T_SDEC) && value[63];

  // field layout
  assign mw_sat  = (mw > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : mw;
  assign place_c = CNT_W'(place);
  assign lim_c   = CNT_W'(lim);
  assign mw_c    = CNT_W'(mw_sat);
  assign pad     = (mw_c > place_c) ? mw_c - place_c : '0;
  assign nd      = (place_c < lim_c) ? place_c : lim_c;
  assign zfill   = pb && zp && (pad != '0);

  always_comb begin
    dig_addr_next = dig_addr;
    if (cmd.setup) begin
      dig_addr_next = AW'(place - PW'(1));
    end else if (cmd.emit && cmd.kind == K_DIG) begin
      dig_addr_next = dig_addr - AW'(1);
    end
  end

  always_comb begin
    case (cmd.kind)
      K_SIGN:  ch = CH_MINUS;
      K_LEAD:  ch = lead_ch;
      K_DIG:   ch = digit_char(rd_data, upper);
      K_TAIL:  ch = CH_SPACE;
      default: ch = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[place[AW-1:0]] <= digit;
    end
    rd_data <= mem[dig_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RESET;
      count      <= '0;
      overflowed <= 1'b0;
      work       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap <= cfg_data;
      end
      if (cmd.load) begin
        if (cmd.restart) begin
          count      <= '0;
          overflowed <= 1'b0;
        end
        work <= in_neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
      end else if (cmd.div_step) begin
        work <= {work[47:0], dq};
      end else if (cmd.store && !is_dec) begin
        work <= work_sh;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (cmd.kind == K_ERR) begin
          overflowed <= 1'b1;
        end else begin
          count <= count + CAP_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem    <= '0;
      chunk  <= '0;
      place  <= '0;
      is_dec <= !(in_oct || in_hex);
      is_hex <= in_hex;
      upper  <= (req_type == T_UHEX);
      neg    <= in_neg;
      pb     <= pad_before;
      zp     <= zero_fill;
      mw     <= field_width;
      lim    <= digit_limit;
    end
    if (cmd.div_step) begin
      rem   <= dr[3:0];
      chunk <= chunk + 2'd1;
    end
    if (cmd.store) begin
      place <= place + PW'(1);
      rem   <= '0;
    end
    if (cmd.setup) begin
      lead       <= pb ? (zfill ? pad - CNT_W'(neg) : pad) : '0;
      tail       <= pb ? '0 : pad;
      dig        <= nd;
      // with zero fill the sign sits in one of the pad slots
      remain     <= pad + nd + CNT_W'(neg && !zfill);
      sign_first <= !pb || zfill;
      lead_ch    <= zfill ? CH_ZERO : CH_SPACE;
    end
    dig_addr <= dig_addr_next;
    if (cmd.emit) begin
      out_char     <= ch;
      out_overflow <= (cmd.kind == K_ERR);
      out_last     <= (cmd.kind == K_ERR) || (remain == CNT_W'(1));
      if (cmd.kind != K_ERR) begin
        remain <= remain - CNT_W'(1);
        case (cmd.kind)
          K_LEAD:  lead <= lead - CNT_W'(1);
          K_DIG:   dig  <= dig - CNT_W'(1);
          K_TAIL:  tail <= tail - CNT_W'(1);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    st.overflowed   = overflowed;
    st.is_dec       = is_dec;
    st.chunk_last   = (chunk == 2'd3);
    st.extract_done = (is_dec ? (work == '0) : (work_sh == '0))
                      || (place == PW'(DIGIT_SLOTS - 1));
    st.total_zero   = (remain == '0);
    st.sign_first   = sign_first;
    st.neg          = neg;
    st.lead_zero    = (lead == '0);
    st.dig_zero     = (dig == '0);
    st.tail_zero    = (tail == '0);
    st.cap_hit      = (count >= cap);
    st.last_char    = (remain == CNT_W'(1));
    st.out_free     = !out_valid || out_ready;
  end

endmodule
